// ===== rtl/core/tdq_pkg.sv =====
// Shared types and constants for the TPDF dither PCM sample quantiser.
package tdq_pkg;

    localparam int FRAC_BITS = 40;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int ACC_W     = 64;
    localparam int DITH_W    = 25;
    localparam int LCG_W     = 32;

    localparam logic [LCG_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [LCG_W-1:0] LCG_ADD = 32'd1013904223;

    localparam logic [1:0] FMT_PCM16 = 2'd0;
    localparam logic [1:0] FMT_PCM24 = 2'd1;
    localparam logic [1:0] FMT_FLOAT = 2'd2;

    localparam logic [2:0] COUNT_PCM16 = 3'd2;
    localparam logic [2:0] COUNT_PCM24 = 3'd3;
    localparam logic [2:0] COUNT_FLOAT = 3'd4;

    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_SCALE16,
        ALU_SCALE24,
        ALU_NEG,
        ALU_DITH,
        ALU_RND
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_NEGX,
        ST_DITH,
        ST_ABS,
        ST_RND,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/tdq_fix.sv =====
// Float to fixed-point magnitude conversion with clamping to one.
module tdq_fix (
    input  logic [31:0]                 sample_bits,
    output logic [tdq_pkg::MAG_W-1:0]   mag,
    output logic                        neg
);

    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] EXP_ONE     = 8'd127;
    localparam logic [7:0] EXP_UNIT    = 8'd110;
    localparam logic [7:0] SIG_BITS    = 8'd24;

    logic [7:0]  exp_raw;
    logic [7:0]  exp_eff;
    logic [22:0] man;
    logic [23:0] sig;
    logic [7:0]  rsh;
    logic [7:0]  lsh;

    assign exp_raw = sample_bits[30:23];
    assign man     = sample_bits[22:0];
    assign exp_eff = (exp_raw == 8'd0) ? 8'd1 : exp_raw;
    assign sig     = (exp_raw == 8'd0) ? {1'b0, man} : {1'b1, man};
    assign rsh     = EXP_UNIT - exp_eff;
    assign lsh     = exp_eff - EXP_UNIT;

    always_comb begin
        neg = sample_bits[31];
        mag = '0;
        if (exp_raw == EXP_SPECIAL) begin
            if (man != 23'd0) begin
                // Not a number counts as silence.
                neg = 1'b0;
            end else begin
                mag = tdq_pkg::MAG_W'(1) << tdq_pkg::FRAC_BITS;
            end
        end else if (exp_raw >= EXP_ONE) begin
            mag = tdq_pkg::MAG_W'(1) << tdq_pkg::FRAC_BITS;
        end else if (exp_eff >= EXP_UNIT) begin
            mag = tdq_pkg::MAG_W'(sig) << lsh[4:0];
        end else if (rsh < SIG_BITS) begin
            mag = tdq_pkg::MAG_W'(sig >> rsh[4:0]);
        end
    end

endmodule

// ===== rtl/core/tdq_lcg.sv =====
// Linear congruential generator that supplies the dither random words.
module tdq_lcg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    output logic [tdq_pkg::LCG_W-1:0]   lcg_state
);

    logic [tdq_pkg::LCG_W-1:0] state_reg;
    logic [tdq_pkg::LCG_W-1:0] state_next;

    assign state_next = state_reg * tdq_pkg::LCG_MUL + tdq_pkg::LCG_ADD;
    assign lcg_state  = state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/tdq_alu.sv =====
// Shared 64-bit adder with operand selection for every arithmetic step.
module tdq_alu (
    input  tdq_pkg::alu_op_t             op,
    input  logic [tdq_pkg::ACC_W-1:0]    acc,
    input  logic [tdq_pkg::MAG_W-1:0]    mag,
    input  logic [tdq_pkg::DITH_W-1:0]   dith,
    output logic [tdq_pkg::ACC_W-1:0]    sum
);

    logic [tdq_pkg::ACC_W-1:0] opa;
    logic [tdq_pkg::ACC_W-1:0] opb;
    logic                      cin;
    logic [tdq_pkg::ACC_W-1:0] mag_ext;
    logic [tdq_pkg::ACC_W-1:0] dith_ext;

    assign mag_ext  = tdq_pkg::ACC_W'(mag);
    assign dith_ext = {{(tdq_pkg::ACC_W - tdq_pkg::DITH_W){dith[tdq_pkg::DITH_W-1]}}, dith};

    always_comb begin
        opa = acc;
        opb = '0;
        cin = 1'b0;
        unique case (op)
            tdq_pkg::ALU_PASS: begin
                opa = acc;
            end
            tdq_pkg::ALU_SCALE16: begin
                // x * 32767 as x * 2^15 - x.
                opa = mag_ext << 15;
                opb = ~mag_ext;
                cin = 1'b1;
            end
            tdq_pkg::ALU_SCALE24: begin
                // x * 8388607 as x * 2^23 - x.
                opa = mag_ext << 23;
                opb = ~mag_ext;
                cin = 1'b1;
            end
            tdq_pkg::ALU_NEG: begin
                opa = '0;
                opb = ~acc;
                cin = 1'b1;
            end
            tdq_pkg::ALU_DITH: begin
                opb = dith_ext << 16;
            end
            tdq_pkg::ALU_RND: begin
                opb = tdq_pkg::ACC_W'(1) << (tdq_pkg::FRAC_BITS - 1);
            end
            default: begin
                opa = acc;
            end
        endcase
    end

    assign sum = opa + opb + tdq_pkg::ACC_W'(cin);

endmodule

// ===== rtl/core/pcm_sample_quantizer_tpdf_dither_unit.sv =====
// Top level of the PCM sample quantiser with TPDF dither.
//
//   Channel   Direction  Handshake                 Word contents
//   s_        in         s_valid / s_ready         s_sample_bits (IEEE single)
//   m_        out        m_valid / m_ready         m_packed_bytes, m_byte_count
//   cfg_      in         cfg_we (no wait)          cfg_wdata = sample format
//
// A word is taken only in the idle state; the sequencer then drives one shared
// 64-bit adder through its steps. The 16-bit mode goes through scale, sign,
// dither, absolute value, round and result, the 24-bit mode through scale,
// round and result and the float mode through the result step alone. A new
// word is taken only after the last has left the result step. Reset is synchronous
// and clears the sequencer, the format register, the generator and m_valid.
// A result waits in the output register while the next word is worked on; the
// sequencer only stalls in its result step when that register is full and m_ready low.
module pcm_sample_quantizer_tpdf_dither_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packed_bytes,
    output logic [2:0]  m_byte_count
);

    tdq_pkg::state_t  state_reg;
    tdq_pkg::state_t  state_next;
    tdq_pkg::alu_op_t alu_op;

    logic [1:0]                    sample_format_reg;
    logic [1:0]                    fmt_reg;
    logic [31:0]                   bits_reg;
    logic [tdq_pkg::MAG_W-1:0]     mag_reg;
    logic                          neg_reg;
    logic                          sgn_reg;
    logic [tdq_pkg::ACC_W-1:0]     acc_reg;
    logic [23:0]                   a1_reg;
    logic [tdq_pkg::DITH_W-1:0]    dith_reg;
    logic                          m_valid_reg;
    logic [31:0]                   packed_reg;
    logic [2:0]                    count_reg;

    logic [tdq_pkg::MAG_W-1:0]     fix_mag;
    logic                          fix_neg;
    logic [tdq_pkg::LCG_W-1:0]     lcg_state;
    logic [tdq_pkg::ACC_W-1:0]     alu_sum;

    logic        accept;
    logic        lcg_step;
    logic        acc_load;
    logic        res_load;
    logic [31:0] res_packed;
    logic [2:0]  res_count;
    logic [16:0] r16;
    logic [15:0] v16;
    logic [23:0] r24;
    logic [7:0]  exp_f;

    tdq_fix u_fix (
        .sample_bits (s_sample_bits),
        .mag         (fix_mag),
        .neg         (fix_neg)
    );

    tdq_lcg u_lcg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (lcg_step),
        .lcg_state (lcg_state)
    );

    tdq_alu u_alu (
        .op   (alu_op),
        .acc  (acc_reg),
        .mag  (mag_reg),
        .dith (dith_reg),
        .sum  (alu_sum)
    );

    assign s_ready = (state_reg == tdq_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and the control of the shared adder and the generator.
    always_comb begin
        state_next = state_reg;
        alu_op     = tdq_pkg::ALU_PASS;
        lcg_step   = 1'b0;
        acc_load   = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            tdq_pkg::ST_IDLE: begin
                if (accept) begin
                    // The first random word is drawn as the sample arrives.
                    lcg_step = (sample_format_reg == tdq_pkg::FMT_PCM16);
                    if (sample_format_reg == tdq_pkg::FMT_PCM16 ||
                        sample_format_reg == tdq_pkg::FMT_PCM24) begin
                        state_next = tdq_pkg::ST_SCALE;
                    end else begin
                        state_next = tdq_pkg::ST_DONE;
                    end
                end
            end
            tdq_pkg::ST_SCALE: begin
                acc_load = 1'b1;
                if (fmt_reg == tdq_pkg::FMT_PCM16) begin
                    alu_op     = tdq_pkg::ALU_SCALE16;
                    lcg_step   = 1'b1;
                    state_next = tdq_pkg::ST_NEGX;
                end else begin
                    alu_op     = tdq_pkg::ALU_SCALE24;
                    state_next = tdq_pkg::ST_RND;
                end
            end
            tdq_pkg::ST_NEGX: begin
                acc_load   = 1'b1;
                alu_op     = neg_reg ? tdq_pkg::ALU_NEG : tdq_pkg::ALU_PASS;
                state_next = tdq_pkg::ST_DITH;
            end
            tdq_pkg::ST_DITH: begin
                acc_load   = 1'b1;
                alu_op     = tdq_pkg::ALU_DITH;
                state_next = tdq_pkg::ST_ABS;
            end
            tdq_pkg::ST_ABS: begin
                acc_load   = 1'b1;
                alu_op     = acc_reg[tdq_pkg::ACC_W-1] ? tdq_pkg::ALU_NEG : tdq_pkg::ALU_PASS;
                state_next = tdq_pkg::ST_RND;
            end
            tdq_pkg::ST_RND: begin
                acc_load   = 1'b1;
                alu_op     = tdq_pkg::ALU_RND;
                state_next = tdq_pkg::ST_DONE;
            end
            tdq_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    res_load   = 1'b1;
                    state_next = tdq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Result formatting from the accumulator, or from the raw bits in float mode.
    assign r16   = acc_reg[tdq_pkg::FRAC_BITS+16:tdq_pkg::FRAC_BITS];
    assign r24   = acc_reg[tdq_pkg::FRAC_BITS+23:tdq_pkg::FRAC_BITS];
    assign exp_f = bits_reg[30:23];

    always_comb begin
        if (sgn_reg) begin
            // Anything at or beyond full scale saturates to the most negative code.
            v16 = r16[16] || r16[15] ? 16'h8000 : 16'(~r16[15:0]) + 16'd1;
        end else begin
            v16 = r16[16] || r16[15] ? 16'h7FFF : r16[15:0];
        end
    end

    always_comb begin
        case (fmt_reg)
            tdq_pkg::FMT_PCM16: begin
                res_packed = {16'd0, v16};
                res_count  = tdq_pkg::COUNT_PCM16;
            end
            tdq_pkg::FMT_PCM24: begin
                res_packed = {8'd0, neg_reg ? (~r24 + 24'd1) : r24};
                res_count  = tdq_pkg::COUNT_PCM24;
            end
            default: begin
                // Not-a-number patterns pass untouched; magnitudes of one or more clamp.
                if (exp_f == 8'hFF && bits_reg[22:0] != 23'd0) begin
                    res_packed = bits_reg;
                end else if (exp_f >= 8'd127) begin
                    res_packed = {bits_reg[31], 31'h3F80_0000};
                end else begin
                    res_packed = bits_reg;
                end
                res_count = tdq_pkg::COUNT_FLOAT;
            end
        endcase
    end

    // Configuration register and output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_format_reg <= tdq_pkg::FMT_PCM16;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                sample_format_reg <= cfg_wdata;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; none of them needs a reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            fmt_reg  <= sample_format_reg;
            bits_reg <= s_sample_bits;
            mag_reg  <= fix_mag;
            neg_reg  <= fix_neg;
        end
        if (state_reg == tdq_pkg::ST_SCALE) begin
            // The generator now holds the first word of this sample.
            a1_reg <= lcg_state[31:8];
        end
        if (state_reg == tdq_pkg::ST_NEGX) begin
            dith_reg <= {1'b0, a1_reg} - {1'b0, lcg_state[31:8]};
        end
        if (state_reg == tdq_pkg::ST_ABS) begin
            sgn_reg <= acc_reg[tdq_pkg::ACC_W-1];
        end
        if (acc_load) begin
            acc_reg <= alu_sum;
        end
        if (res_load) begin
            packed_reg <= res_packed;
            count_reg  <= res_count;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_packed_bytes = packed_reg;
    assign m_byte_count   = count_reg;

endmodule

// ===== tb/tb_pcm_sample_quantizer_tpdf_dither_unit.sv =====
// Self-checking testbench for the PCM sample quantiser with TPDF dither.
`timescale 1ns / 1ps

module tb_pcm_sample_quantizer_tpdf_dither_unit;
    import tdq_pkg::*;

    // The spare format code must behave as float passthrough.
    localparam logic [1:0]  FMT_SPARE = 2'd3;
    localparam logic [63:0] MAG_ONE   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MAG_HALF  = 64'd1 << (FRAC_BITS - 1);
    localparam int          EDGE_N    = 22;

    // Samples that sit on the corners of the conversion: signed zeros, the
    // clamp boundary, infinities, both kinds of NaN, denormals, the largest
    // finite values and magnitudes on either side of the truncation limit.
    localparam logic [31:0] EDGE_SAMPLES [EDGE_N] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
        32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F00_0000,
        32'hBF00_0000, 32'h4000_0000, 32'h0080_0000, 32'h3400_0000,
        32'h2B80_0000, 32'hAB00_0000
    };

    typedef struct packed {
        logic [31:0] packed_bytes;
        logic [2:0]  byte_count;
    } pcm_word_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [1:0]  cfg_wdata      = FMT_PCM16;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [31:0] s_sample_bits  = 32'd0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_packed_bytes;
    logic [2:0]  m_byte_count;

    // Stimulus waiting to be sent, and the words we expect back in order.
    logic [31:0] sample_queue [$];
    pcm_word_t   pcm_expected_q [$];

    // Our own copy of the generator's state and of the format register.
    logic [31:0] lcg_state;
    logic [1:0]  format_model;

    logic        word_taken   = 1'b0;
    logic        idle_on      = 1'b1;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned mismatch_count = 0;
    int unsigned words_checked  = 0;
    int unsigned format_words [4] = '{0, 0, 0, 0};

    pcm_sample_quantizer_tpdf_dither_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_bits  (s_sample_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_bytes (m_packed_bytes),
        .m_byte_count   (m_byte_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the PCM word for one sample under the current format. The
    // sample is clamped to [-1, +1] and held as a magnitude with 40 fraction
    // bits, truncated toward zero; NaN becomes a positive zero.
    function automatic pcm_word_t quantise_sample(input logic [31:0] bits);
        pcm_word_t   word;
        logic [7:0]  expo;
        logic [22:0] mant;
        logic [63:0] signif;
        logic [63:0] mag;
        logic [63:0] smag;
        logic [31:0] v24;
        logic [23:0] dith_a;
        logic [23:0] dith_b;
        int unsigned ex;
        logic        neg;
        longint      x;
        longint      sum;
        longint      v16;

        expo = bits[30:23];
        mant = bits[22:0];
        neg  = bits[31];
        if (expo == 8'hFF && mant != 23'd0) begin
            neg = 1'b0;
            mag = 64'd0;
        end else if (expo >= 8'd127) begin
            mag = MAG_ONE;
        end else begin
            // Denormals use the minimum exponent and no hidden bit.
            if (expo == 8'd0) begin
                signif = {41'd0, mant};
                ex = 1;
            end else begin
                signif = {40'd0, 1'b1, mant};
                ex = 32'(expo);
            end
            if (ex >= 110)
                mag = signif << (ex - 110);
            else if (110 - ex >= 64)
                mag = 64'd0;
            else
                mag = signif >> (110 - ex);
        end

        case (format_model)
            FMT_PCM16: begin
                // Two generator steps; the difference of their top 24 bits
                // gives a triangular dither of up to one LSB either way.
                lcg_state = lcg_state * LCG_MUL + LCG_ADD;
                dith_a = lcg_state[31:8];
                lcg_state = lcg_state * LCG_MUL + LCG_ADD;
                dith_b = lcg_state[31:8];
                x = longint'(mag * 64'd32767);
                if (neg)
                    x = -x;
                sum = x + (longint'({40'd0, dith_a}) - longint'({40'd0, dith_b})) * 65536;
                smag = (sum < 0) ? 64'(-sum) : 64'(sum);
                v16 = longint'((smag + MAG_HALF) >> FRAC_BITS);
                if (sum < 0)
                    v16 = -v16;
                if (v16 > 32767)
                    v16 = 32767;
                if (v16 < -32768)
                    v16 = -32768;
                word.packed_bytes = {16'd0, v16[15:0]};
                word.byte_count   = COUNT_PCM16;
            end
            FMT_PCM24: begin
                smag = (mag * 64'd8388607 + MAG_HALF) >> FRAC_BITS;
                v24 = smag[31:0];
                if (neg)
                    v24 = 32'd0 - v24;
                word.packed_bytes = {8'd0, v24[23:0]};
                word.byte_count   = COUNT_PCM24;
            end
            default: begin
                // Float mode and the spare code: NaN passes untouched, large
                // magnitudes and infinities become a signed one.
                if (expo == 8'hFF && mant != 23'd0)
                    word.packed_bytes = bits;
                else if (expo >= 8'd127)
                    word.packed_bytes = {bits[31], 31'h3F80_0000};
                else
                    word.packed_bytes = bits;
                word.byte_count = COUNT_FLOAT;
            end
        endcase
        return word;
    endfunction

    // Monitor: samples both handshakes at the rising edge, predicts every
    // accepted sample and checks every accepted result against the oldest
    // expectation.
    always @(posedge aclk) begin
        pcm_word_t want;
        if (!aresetn) begin
            lcg_state    = 32'd0;
            format_model = FMT_PCM16;
            word_taken   = 1'b0;
        end else begin
            if (cfg_we)
                format_model = cfg_wdata;
            word_taken = s_valid && s_ready;
            if (word_taken) begin
                format_words[format_model]++;
                pcm_expected_q.push_back(quantise_sample(s_sample_bits));
            end
            if (m_valid && m_ready) begin
                if (pcm_expected_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, actual bytes %h count %0d",
                             $time, m_packed_bytes, m_byte_count);
                end else begin
                    want = pcm_expected_q.pop_front();
                    words_checked++;
                    if (m_packed_bytes !== want.packed_bytes) begin
                        mismatch_count++;
                        $display("%0t: packed_bytes expected %h actual %h",
                                 $time, want.packed_bytes, m_packed_bytes);
                    end
                    if (m_byte_count !== want.byte_count) begin
                        mismatch_count++;
                        $display("%0t: byte_count expected %0d actual %0d",
                                 $time, want.byte_count, m_byte_count);
                    end
                end
            end
        end
    end

    // Driver: all inputs change at the falling edge. A word that has been
    // offered stays put until the monitor has seen it taken; otherwise the
    // sender may open an idle burst or present the next sample. The receiver
    // independently opens stall bursts of its own.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (s_valid && !word_taken) begin
                // Hold the current word until it is accepted.
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 8) - 1;
                s_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                s_valid       <= 1'b1;
                s_sample_bits <= sample_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end

            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Waits until every queued sample has been taken and every expected word
    // has come back. Checked at the rising edge, where the driver's state is
    // settled.
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (sample_queue.size() != 0 || s_valid || pcm_expected_q.size() != 0);
    endtask

    // The format register is only written while the block has nothing in hand.
    task automatic write_format(input logic [1:0] code);
        wait_drained();
        @(negedge aclk);
        cfg_wdata <= code;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // A phase of random samples. Most lie around the clamp range with random
    // sign and mantissa, so that the rounding and dither paths are exercised;
    // the rest are raw bit patterns and the special encodings.
    task automatic run_random_phase(input int count, input bit midway_drain);
        logic [31:0] bits;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                    bits = $urandom();
                3:
                    bits = {$urandom_range(0, 1) == 1, 8'hFF,
                            ($urandom_range(0, 1) == 1) ? 23'(0) : 23'($urandom())};
                4:
                    bits = {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
                5, 6, 7:
                    bits = {$urandom_range(0, 1) == 1, 8'($urandom_range(125, 128)),
                            23'($urandom())};
                default:
                    bits = {$urandom_range(0, 1) == 1, 8'($urandom_range(95, 127)),
                            23'($urandom())};
            endcase
            sample_queue.push_back(bits);
            // Hold the sender back until the block has emptied completely,
            // so that it restarts from fully idle mid-phase.
            if (midway_drain && i == count / 2)
                wait_drained();
        end
    endtask

    initial begin
        // Synchronous reset, released at a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The corner samples under every format code, the reset default
        // first and the spare code last.
        foreach (EDGE_SAMPLES[i])
            sample_queue.push_back(EDGE_SAMPLES[i]);
        write_format(FMT_PCM24);
        foreach (EDGE_SAMPLES[i])
            sample_queue.push_back(EDGE_SAMPLES[i]);
        write_format(FMT_FLOAT);
        foreach (EDGE_SAMPLES[i])
            sample_queue.push_back(EDGE_SAMPLES[i]);
        write_format(FMT_SPARE);
        foreach (EDGE_SAMPLES[i])
            sample_queue.push_back(EDGE_SAMPLES[i]);

        // Random phases switching format between them. One runs without any
        // idling, one pauses for a full drain half way, and the last one runs
        // flat out with no idling at all.
        write_format(FMT_PCM16);
        run_random_phase(88, 1'b1);
        write_format(FMT_PCM24);
        run_random_phase(88, 1'b0);
        write_format(FMT_FLOAT);
        idle_on = 1'b0;
        run_random_phase(88, 1'b0);
        wait_drained();
        idle_on = 1'b1;
        write_format(FMT_SPARE);
        run_random_phase(88, 1'b0);
        write_format(FMT_PCM16);
        run_random_phase(88, 1'b0);
        write_format(FMT_PCM24);
        run_random_phase(88, 1'b0);
        wait_drained();
        idle_on = 1'b0;
        write_format(FMT_PCM16);
        run_random_phase(88, 1'b0);

        // Let the block settle for longer than its slowest word, then make
        // sure nothing is still owed.
        wait_drained();
        repeat (16) @(posedge aclk);
        if (pcm_expected_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected words never arrived", $time,
                     pcm_expected_q.size());
        end

        $display("Checked %0d words: %0d as 16-bit dithered, %0d as 24-bit,",
                 words_checked, format_words[0], format_words[1]);
        $display("%0d as float and %0d under the spare format code.",
                 format_words[2], format_words[3]);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Safety net: far beyond the slowest legal run of some 700 words.
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
